// ===== hdl/dss_pkg.sv =====
package dss_pkg;
    localparam int NUM_SETS   = 2048;
    localparam int NUM_WAYS   = 16;
    localparam int BIM_INT    = 32;
    localparam int LEADERS    = 64;
    localparam int SET_W      = 11;
    localparam int WAY_W      = 4;
    localparam int LINE_W     = 42;
    localparam int PC_W       = 18;
    localparam int SIG_W      = 6;
    localparam int BIM_W      = 5;
    localparam int SEL_W      = 10;
    localparam int CLR_W      = SET_W + 1;
    localparam int LEADER_GAP = NUM_SETS / LEADERS;

    localparam logic [1:0] RRPV_MAX     = 2'd3;
    localparam logic [1:0] RRPV_MRU     = 2'd0;
    localparam logic [1:0] RRPV_DISTANT = 2'd2;
    localparam logic [SEL_W-1:0] SEL_MAX = 10'd1023;
    localparam logic [SEL_W-1:0] SEL_MID = 10'd512;

    // Per-set row: RRPVs, signatures, stride history
    typedef struct packed {
        logic [NUM_WAYS-1:0][1:0]      rrpv;
        logic [NUM_WAYS-1:0][SIG_W-1:0] sig;
        logic [LINE_W-1:0]             last;
        logic [1:0]                    run;
        logic                          flag;
        logic [3:0]                    cnt;
    } row_t;

    localparam row_t ROW_RESET = '{rrpv: {NUM_WAYS{RRPV_MAX}}, sig: '0, last: '0,
                                   run: '0, flag: 1'b0, cnt: '0};

    function automatic logic [SIG_W-1:0] hash_pc(input logic [PC_W-1:0] pc);
        logic [PC_W-1:0] h;
        h = pc ^ (pc >> 6) ^ (pc >> 12);
        return h[SIG_W-1:0];
    endfunction

    function automatic logic is_leader_base(input logic [SET_W-1:0] s);
        return (s % LEADER_GAP) == 0 && (s / LEADER_GAP) < (LEADERS / 2);
    endfunction
endpackage

// ===== hdl/dss_row_ram.sv =====
module dss_row_ram (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [dss_pkg::SET_W-1:0] waddr,
    input  dss_pkg::row_t            wdata,
    input  logic [dss_pkg::SET_W-1:0] raddr,
    output dss_pkg::row_t            rdata
);
    import dss_pkg::*;
    row_t mem [NUM_SETS];

    // Write one row, read one row with registered data
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/drrip_ship_stream_replacement_top.sv =====
// Replacement engine for a last-level cache (DRRIP, SHiP-lite predictor,
// per-set stream bypass).
// s_axis carries one item: a victim query (tuser = 0) or a state update
// (tuser = 1). m_axis returns one result item for every input item.
// An accepted item moves through the states in order: ST_READ reads the
// set row from the row memory, ST_LOOK reads the reuse counter that the
// item needs, and ST_EXEC computes and writes back the row and the
// counter. The result is registered on m_axis as ST_EXEC ends, and no
// new item is taken before the engine is back in ST_IDLE.
// After reset a clearing pass writes every set row, one row a cycle, and
// sets the 64 reuse counters while it writes the first 64 rows;
// s_axis_tready stays low during it. Configuration writes
// (cfg_we/cfg_wdata, the stream window length) are taken at any time.
// When the receiver stalls, the result holds in the output register; the
// next item may still be taken and read, but it is not computed until the
// waiting result is taken.
module drrip_ship_stream_replacement_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // set_index[10:0], way_index[14:11], line_address[56:15], pc_low[74:57],
    // hit[75], zero fill
    input  logic [79:0] s_axis_tdata,
    // kind
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // victim_way[3:0], bypass_active[4], zero fill
    output logic [7:0]  m_axis_tdata
);
    import dss_pkg::*;

    typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_LOOK, ST_EXEC} state_t;
    state_t state_reg;

    logic [CLR_W-1:0]  clr_reg;
    logic [3:0]        wlen_reg;
    logic              kind_reg, hit_reg;
    logic [SET_W-1:0]  set_reg;
    logic [WAY_W-1:0]  way_reg;
    logic [LINE_W-1:0] line_reg;
    logic [PC_W-1:0]   pc_reg;
    logic [SEL_W-1:0]  sel_reg;
    logic [BIM_W-1:0]  bim_reg;
    logic              ovalid_reg;
    logic [7:0]        odata_reg;

    row_t              rd_row, wr_row;
    logic              we;
    logic [SET_W-1:0]  waddr;

    logic [1:0]        reuse_mem [64];
    logic [1:0]        reuse_q;
    logic              reuse_we;
    logic [SIG_W-1:0]  reuse_raddr, reuse_waddr;
    logic [1:0]        reuse_wdata;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;

    dss_row_ram u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wr_row),
        .raddr(set_reg), .rdata(rd_row)
    );

    // Reuse counters: one write, one read with registered data
    always_ff @(posedge aclk) begin
        if (reuse_we) begin
            reuse_mem[reuse_waddr] <= reuse_wdata;
        end
        reuse_q <= reuse_mem[reuse_raddr];
    end

    // Compute the new row and counter updates from the read row
    logic [1:0]  rrpv_n [NUM_WAYS];
    logic [3:0]  vict;
    logic        found, aged_found, unit, sr, br, wopen, bypass;
    logic [1:0]  run_n;
    logic        flag_n;
    logic [3:0]  cnt_n;
    logic [SIG_W-1:0] sig, old_sig;
    logic [1:0]  ins;
    row_t        upd_row;

    always_comb begin
        upd_row = rd_row;
        sig = hash_pc(pc_reg);
        old_sig = rd_row.sig[way_reg];
        sr = is_leader_base(set_reg);
        br = (set_reg != '0) && is_leader_base(set_reg - 1'b1);
        found = 1'b0;
        aged_found = 1'b0;
        vict = '0;
        // Find the first way at the maximum RRPV
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (rd_row.rrpv[w] == RRPV_MAX) begin
                found = 1'b1;
                vict = WAY_W'(w);
            end
        end
        // Age once and search again (max after aging means 2 before)
        if (!found) begin
            for (int w = NUM_WAYS - 1; w >= 0; w--) begin
                if (rd_row.rrpv[w] == RRPV_DISTANT) begin
                    aged_found = 1'b1;
                    vict = WAY_W'(w);
                end
            end
            for (int w = 0; w < NUM_WAYS; w++) begin
                rrpv_n[w] = rd_row.rrpv[w] + 2'd1;
            end
        end else begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                rrpv_n[w] = rd_row.rrpv[w];
            end
        end
        if (!aged_found && !found) begin
            vict = '0;
        end
        // Stride detector, compared one bit wider so the line number never wraps
        unit = (rd_row.last != '0) &&
               (({1'b0, line_reg} == {1'b0, rd_row.last} + (LINE_W+1)'(1)) ||
                ({1'b0, rd_row.last} == {1'b0, line_reg} + (LINE_W+1)'(1)));
        run_n = rd_row.run;
        flag_n = rd_row.flag;
        cnt_n = rd_row.cnt;
        if (unit) begin
            if (run_n != 2'd3) begin
                run_n = run_n + 2'd1;
            end
            if (run_n == 2'd3 && !flag_n) begin
                flag_n = 1'b1;
                cnt_n = wlen_reg;
            end
        end else begin
            run_n = '0;
            flag_n = 1'b0;
            cnt_n = '0;
        end
        wopen = flag_n && (cnt_n != '0);
        if (wopen) begin
            cnt_n = cnt_n - 4'd1;
        end
        bypass = flag_n && (cnt_n != '0);
        ins = (reuse_q >= 2'd2) ? RRPV_MRU : RRPV_DISTANT;
        if (!sr && br && bim_reg != '0) begin
            ins = RRPV_DISTANT;
        end
        if (!kind_reg) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                upd_row.rrpv[w] = rrpv_n[w];
            end
            bypass = rd_row.flag && (rd_row.cnt != '0);
        end else begin
            upd_row.last = line_reg;
            upd_row.run = run_n;
            upd_row.flag = flag_n;
            upd_row.cnt = cnt_n;
            if (bypass) begin
                if (hit_reg) begin
                    upd_row.rrpv[way_reg] = RRPV_MRU;
                end
            end else if (hit_reg) begin
                upd_row.rrpv[way_reg] = RRPV_MRU;
            end else begin
                upd_row.rrpv[way_reg] = ins;
                upd_row.sig[way_reg] = sig;
            end
        end
    end

    // Select memory writes: clearing pass or write-back
    always_comb begin
        reuse_raddr = hit_reg ? old_sig : sig;
        if (state_reg == ST_CLEAR) begin
            we = 1'b1;
            waddr = clr_reg[SET_W-1:0];
            wr_row = ROW_RESET;
            reuse_we = (clr_reg < CLR_W'(64));
            reuse_waddr = clr_reg[SIG_W-1:0];
            reuse_wdata = 2'd1;
        end else begin
            we = (state_reg == ST_EXEC);
            waddr = set_reg;
            wr_row = upd_row;
            reuse_we = (state_reg == ST_EXEC) && kind_reg && !bypass;
            reuse_waddr = reuse_raddr;
            if (hit_reg) begin
                reuse_wdata = (reuse_q != 2'd3) ? reuse_q + 2'd1 : reuse_q;
            end else begin
                reuse_wdata = (reuse_q != 2'd0) ? reuse_q - 2'd1 : reuse_q;
            end
        end
    end

    // Sequencer, shared counters and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            wlen_reg   <= 4'd8;
            sel_reg    <= SEL_MID;
            bim_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                wlen_reg <= cfg_wdata;
            end
            if (ovalid_reg && m_axis_tready) begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == CLR_W'(NUM_SETS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        kind_reg  <= s_axis_tuser;
                        set_reg   <= s_axis_tdata[10:0];
                        way_reg   <= s_axis_tdata[14:11];
                        line_reg  <= s_axis_tdata[56:15];
                        pc_reg    <= s_axis_tdata[74:57];
                        hit_reg   <= s_axis_tdata[75];
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: state_reg <= ST_LOOK;
                // Hold until the output register is free at the compute edge
                ST_LOOK: begin
                    if (!ovalid_reg || m_axis_tready) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    state_reg  <= ST_IDLE;
                    ovalid_reg <= 1'b1;
                    odata_reg  <= {3'b000, bypass, kind_reg ? 4'd0 : vict};
                    if (kind_reg && !bypass) begin
                        if (!sr && br) begin
                            bim_reg <= bim_reg + 1'b1;
                        end
                        if (hit_reg) begin
                            if (sr && !br && sel_reg != SEL_MAX) begin
                                sel_reg <= sel_reg + 1'b1;
                            end
                            if (br && !sr && sel_reg != '0) begin
                                sel_reg <= sel_reg - 1'b1;
                            end
                        end else begin
                            if (sr && !br && sel_reg != '0) begin
                                sel_reg <= sel_reg - 1'b1;
                            end
                            if (br && !sr && sel_reg != SEL_MAX) begin
                                sel_reg <= sel_reg + 1'b1;
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// ===== hdl/dss_checker.sv =====
module dss_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);
    // A result is held while the receiver stalls
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");

    // An item accepted while the output is empty shows its result without a stall
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##3 m_axis_tvalid)
        else $error("result missing");

    // Only one item in the engine at a time
    a_block: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item accepted while busy");

    // Fill bits stay zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[7:5] == 3'b000)
        else $error("nonzero fill");
endmodule

bind drrip_ship_stream_replacement_top dss_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import dss_pkg::*;

    localparam int ITEM_COUNT = 400;
    localparam logic KIND_QUERY  = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    typedef struct {
        logic             kind;
        logic [SET_W-1:0]  set_index;
        logic [WAY_W-1:0]  way_index;
        logic [LINE_W-1:0] line_address;
        logic [PC_W-1:0]   pc_low;
        logic              hit;
    } access_t;

    typedef struct {
        logic [WAY_W-1:0] victim_way;
        logic             bypass_active;
    } verdict_t;

    // Replacement-state predictor plus queue of expected verdicts
    class replacement_scoreboard;
        logic [1:0]        rrpv [NUM_SETS][NUM_WAYS];
        logic [SIG_W-1:0]  sig [NUM_SETS][NUM_WAYS];
        logic [1:0]        reuse [64];
        logic [SEL_W-1:0]  selector;
        logic [BIM_W-1:0]  bimodal;
        logic [LINE_W-1:0] last_line [NUM_SETS];
        logic [1:0]        run [NUM_SETS];
        logic              flag [NUM_SETS];
        logic [3:0]        countdown [NUM_SETS];
        logic [3:0]        window_len;
        verdict_t          pending [$];
        int                mismatches;
        int                checked;

        function new();
            for (int s = 0; s < NUM_SETS; s++) begin
                for (int w = 0; w < NUM_WAYS; w++) begin
                    rrpv[s][w] = RRPV_MAX;
                    sig[s][w] = '0;
                end
                last_line[s] = '0;
                run[s] = '0;
                flag[s] = 1'b0;
                countdown[s] = '0;
            end
            for (int i = 0; i < 64; i++) reuse[i] = 2'd1;
            selector = SEL_MID;
            bimodal = '0;
            window_len = 4'd8;
            mismatches = 0;
            checked = 0;
        endfunction

        function bit sr_base(int s);
            return (s % LEADER_GAP) == 0 && (s / LEADER_GAP) < (LEADERS / 2);
        endfunction

        function int first_distant(int s);
            for (int w = 0; w < NUM_WAYS; w++)
                if (rrpv[s][w] == RRPV_MAX) return w;
            return -1;
        endfunction

        function void note_access(access_t a);
            verdict_t v;
            int s, w, vic;
            bit unit, sr, br;
            logic [LINE_W-1:0] prev;
            logic [PC_W-1:0] h;
            logic [SIG_W-1:0] pcs, old;
            logic [1:0] ins;
            s = a.set_index;
            w = a.way_index;
            v.victim_way = '0;
            if (a.kind == KIND_QUERY) begin
                vic = first_distant(s);
                if (vic < 0) begin
                    for (int k = 0; k < NUM_WAYS; k++)
                        if (rrpv[s][k] < RRPV_MAX) rrpv[s][k]++;
                    vic = first_distant(s);
                end
                v.victim_way = (vic < 0) ? '0 : WAY_W'(vic);
            end else begin
                prev = last_line[s];
                unit = prev != 0 &&
                       ({1'b0, a.line_address} == {1'b0, prev} + (LINE_W+1)'(1) ||
                        {1'b0, prev} == {1'b0, a.line_address} + (LINE_W+1)'(1));
                sr = sr_base(s);
                br = s > 0 && sr_base(s - 1);
                h = a.pc_low ^ (a.pc_low >> 6) ^ (a.pc_low >> 12);
                pcs = h[SIG_W-1:0];
                // stride detector
                if (unit) begin
                    if (run[s] < 3) run[s]++;
                    if (run[s] == 3 && !flag[s]) begin
                        flag[s] = 1'b1;
                        countdown[s] = window_len;
                    end
                end else begin
                    run[s] = '0;
                    flag[s] = 1'b0;
                    countdown[s] = '0;
                end
                last_line[s] = a.line_address;
                if (flag[s] && countdown[s] != 0) countdown[s]--;
                if (flag[s] && countdown[s] != 0) begin
                    if (a.hit) rrpv[s][w] = RRPV_MRU;
                end else begin
                    ins = (reuse[pcs] >= 2) ? RRPV_MRU : RRPV_DISTANT;
                    if (!sr && br) begin
                        if (bimodal != 0) ins = RRPV_DISTANT;
                        bimodal = bimodal + 1'b1;
                    end
                    if (a.hit) begin
                        old = sig[s][w];
                        rrpv[s][w] = RRPV_MRU;
                        if (reuse[old] < 3) reuse[old]++;
                        if (sr && selector < SEL_MAX) selector++;
                        if (br && selector > 0) selector--;
                    end else begin
                        sig[s][w] = pcs;
                        rrpv[s][w] = ins;
                        if (reuse[pcs] > 0) reuse[pcs]--;
                        if (sr && selector > 0) selector--;
                        if (br && selector < SEL_MAX) selector++;
                    end
                end
            end
            v.bypass_active = flag[s] && countdown[s] != 0;
            pending.push_back(v);
        endfunction

        function void check_verdict(logic [7:0] data);
            verdict_t e;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result item %h", data);
                return;
            end
            e = pending.pop_front();
            if (data[3:0] !== e.victim_way || data[4] !== e.bypass_active
                    || data[7:5] !== 3'b0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected way %0d bypass %0b, got way %0d bypass %0b",
                             e.victim_way, e.bypass_active, data[3:0], data[4]);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [3:0]  cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;

    replacement_scoreboard sb = new();
    int bypass_seen = 0;
    bit stall_on = 1'b0;

    always #1 aclk = ~aclk;

    drrip_ship_stream_replacement_top u_top (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // Receiver: check accepted results, stall on its own pattern
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (m_axis_tdata[4]) bypass_seen++;
            sb.check_verdict(m_axis_tdata);
        end
        if (!stall_on) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    // Present one item and hold it until accepted
    task automatic send_item(access_t a);
        s_axis_tdata <= {4'b0, a.hit, a.pc_low, a.line_address, a.way_index, a.set_index};
        s_axis_tuser <= a.kind;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_access(a);
    endtask

    task automatic drop_valid();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_window(logic [3:0] len);
        cfg_we <= 1'b1;
        cfg_wdata <= len;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.window_len = len;
    endtask

    function automatic access_t rand_access(bit update);
        access_t a;
        a.kind = update;
        a.set_index = $urandom_range(0, 15) == 0 ? SET_W'($urandom) :
                      SET_W'($urandom_range(0, 3) * LEADER_GAP + $urandom_range(0, 2));
        a.way_index = WAY_W'($urandom);
        a.line_address = {10'($urandom), 32'($urandom)};
        a.pc_low = PC_W'($urandom);
        a.hit = $urandom_range(0, 1);
        return a;
    endfunction

    // Burst sender: runs of lines near a base address on one set, plus noise
    task automatic random_phase(int count);
        access_t a;
        int burst;
        logic [LINE_W-1:0] base;
        burst = $urandom_range(1, 12);
        for (int n = 0; n < count; n++) begin
            a = rand_access($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1) == 0) begin
                base = {10'($urandom), 32'($urandom)};
                for (int k = 0; k < $urandom_range(3, 10) && n < count; k++) begin
                    a.kind = ($urandom_range(0, 5) == 0) ? KIND_QUERY : KIND_UPDATE;
                    a.line_address = ($urandom_range(0, 1)) ? base + k : base - k;
                    a.way_index = WAY_W'($urandom);
                    a.hit = $urandom_range(0, 1);
                    send_item(a);
                    n++;
                end
            end else begin
                send_item(a);
            end
            if (--burst <= 0) begin
                burst = $urandom_range(1, 12);
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end
        end
        drop_valid();
    endtask

    initial begin
        access_t a;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, queries on fresh and aged sets, leaders, streams
        write_window(4'd15);
        a = '{KIND_QUERY, '0, '0, '0, '0, 1'b0};
        send_item(a);
        a = '{KIND_UPDATE, '0, '0, '0, '0, 1'b0};
        send_item(a);
        a = '{KIND_UPDATE, 11'd2047, 4'd15, {LINE_W{1'b1}}, {PC_W{1'b1}}, 1'b1};
        send_item(a);
        a = '{KIND_UPDATE, 11'd2047, 4'd15, '0, {PC_W{1'b1}}, 1'b0};
        send_item(a);
        for (int k = 0; k < NUM_WAYS; k++) begin
            a = '{KIND_UPDATE, 11'd5, WAY_W'(k), 42'd1000 + 2 * k, 18'd77, 1'b1};
            send_item(a);
        end
        a = '{KIND_QUERY, 11'd5, '0, '0, '0, 1'b0};
        send_item(a);
        send_item(a);
        for (int k = 0; k < 6; k++) begin
            a = '{KIND_UPDATE, 11'(LEADER_GAP + 1), WAY_W'(k), 42'd500 - k, 18'h2A5, 1'b1};
            send_item(a);
        end
        drop_valid();
        wait_drained();

        // Zero window: the flag sets but no window opens
        write_window(4'd0);
        for (int k = 0; k < 5; k++) begin
            a = '{KIND_UPDATE, 11'd9, WAY_W'(k), 42'd40 + k, 18'd3, 1'b1};
            send_item(a);
        end
        drop_valid();
        wait_drained();

        // Random phases at several window lengths, the receiver stalling in the second and third
        stall_on = 1'b0;
        random_phase(80);
        wait_drained();
        write_window(4'd1);
        stall_on = 1'b1;
        random_phase(110);
        wait_drained();
        write_window(4'd15);
        random_phase(110);
        wait_drained();
        write_window(4'($urandom_range(2, 14)));
        stall_on = 1'b0;
        random_phase(ITEM_COUNT - 300);
        wait_drained();

        $display("Checked %0d result items, %0d with stream bypass open, mismatches %0d",
                 sb.checked, bypass_seen, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Run limit: clearing pass plus generous per-item margin
    initial begin
        #400000;
        $display("Timeout waiting for results");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/dss_pkg.sv
hdl/dss_row_ram.sv
hdl/drrip_ship_stream_replacement_top.sv
hdl/dss_checker.sv
dv/tb.sv
